[rtl/kmb_pkg.sv]
// Shared types and constants for the keyed message buffer.
// Holds the request/response payload structs, the operation codes and the entry layout.
// No dependencies.
package kmb_pkg;

  // Capacity used when the top level is not overridden
  localparam int unsigned DEFAULT_CAPACITY = 16;

  // Operation codes carried in the request
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_PEEK   = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  // One request transfer
  typedef struct packed {
    func_e       func;
    logic [31:0] seq_num;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [63:0] payload;
  } req_t;

  // One response transfer
  typedef struct packed {
    logic        found;
    logic [63:0] payload_out;
    logic        evicted;
    logic [4:0]  entry_count;
    logic        is_empty;
  } rsp_t;

  // One stored entry, as laid out in the entry memory
  typedef struct packed {
    logic [31:0] seq_num;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [63:0] payload;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

[rtl/keyed_message_buffer_core.sv]
// Keyed message buffer: age-ordered ring of entries in one RAM plus the operation sequencer.
// Depends on kmb_pkg and kmb_ram.
//
// Entries sit in a ring in a single-port-read, single-port-write RAM; newest_q points at the
// newest entry and count_q holds the number of entries. A transfer is taken when start_i is
// high and busy_o is low; its result appears on rsp_o for exactly one cycle with done_o high
// and cannot be held off. Insert and clear, and peek or remove on an empty buffer, give their
// result in the cycle after the transfer and leave the block ready in that same cycle. Peek
// and remove scan the RAM from newest to oldest at one entry per cycle and stop at the first
// hit, or after the oldest entry on a miss. A remove that hits at age i > 0 (0 is newest)
// then closes the gap by moving the i newer entries down one slot, one RAM read and one
// write per cycle. busy_o is high for the whole scan and compaction.
module keyed_message_buffer_core #(
  parameter int unsigned CAPACITY = kmb_pkg::DEFAULT_CAPACITY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  kmb_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output kmb_pkg::rsp_t rsp_o
);

  import kmb_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_C = AW'(CAPACITY - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] newest_q, newest_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [CW-1:0] lidx_q, lidx_d;
  logic [CW-1:0] moves_q, moves_d;
  req_t          req_q, req_d;
  rsp_t          rsp_q, rsp_d;
  logic          done_q, done_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_ent;
  entry_t             new_ent;
  logic               key_hit;
  logic [CW+4:0]      count_ext;

  // Step one slot toward newer entries around the ring
  function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] s);
    slot_next = (s == LAST_C) ? '0 : AW'(s + 1'b1);
  endfunction

  // Step one slot toward older entries around the ring
  function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] s);
    slot_prev = (s == '0) ? LAST_C : AW'(s - 1'b1);
  endfunction

  kmb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Compare the entry read last cycle against the held key
  assign rd_ent  = entry_t'(ram_rdata);
  assign key_hit = (rd_ent.seq_num == req_q.seq_num) &&
                   (rd_ent.peer_addr == req_q.peer_addr) &&
                   (rd_ent.peer_port == req_q.peer_port);

  assign new_ent.seq_num   = req_i.seq_num;
  assign new_ent.peer_addr = req_i.peer_addr;
  assign new_ent.peer_port = req_i.peer_port;
  assign new_ent.payload   = req_i.payload;

  // Next-state and RAM control
  always_comb begin
    state_d   = state_q;
    newest_d  = newest_q;
    count_d   = count_q;
    slot_d    = slot_q;
    lidx_d    = lidx_q;
    moves_d   = moves_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = ram_rdata;
    ram_raddr = slot_q;
    count_ext = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          rsp_d = '0;
          case (req_i.func)
            FUNC_INSERT: begin
              // Write the new entry one slot past the newest; overwrite the oldest when full
              ram_we    = 1'b1;
              ram_waddr = slot_next(newest_q);
              ram_wdata = new_ent;
              newest_d  = slot_next(newest_q);
              if (count_q == CAP_C) begin
                rsp_d.evicted = 1'b1;
              end else begin
                count_d = CW'(count_q + 1'b1);
              end
              done_d = 1'b1;
            end
            FUNC_PEEK, FUNC_REMOVE: begin
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                // Start the scan at the newest entry
                ram_raddr = newest_q;
                slot_d    = newest_q;
                lidx_d    = '0;
                state_d   = ST_SCAN;
              end
            end
            FUNC_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Fetch the next older entry while checking this one
        ram_raddr = slot_prev(slot_q);
        slot_d    = slot_prev(slot_q);
        lidx_d    = CW'(lidx_q + 1'b1);
        if (key_hit) begin
          rsp_d.found       = 1'b1;
          rsp_d.payload_out = rd_ent.payload;
          if ((req_q.func == FUNC_REMOVE) && (lidx_q != '0)) begin
            // Move the newer entries down over the hit slot
            ram_raddr = slot_next(slot_q);
            slot_d    = slot_q;
            moves_d   = lidx_q;
            state_d   = ST_SHIFT;
          end else begin
            if (req_q.func == FUNC_REMOVE) begin
              newest_d = slot_prev(newest_q);
              count_d  = CW'(count_q - 1'b1);
            end
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (lidx_q == CW'(count_q - 1'b1)) begin
          // Oldest entry checked without a match
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_SHIFT: begin
        // Write the entry read from the next newer slot and fetch the one after it
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        ram_wdata = ram_rdata;
        ram_raddr = slot_next(slot_next(slot_q));
        slot_d    = slot_next(slot_q);
        moves_d   = CW'(moves_q - 1'b1);
        if (moves_q == CW'(1)) begin
          newest_d = slot_prev(newest_q);
          count_d  = CW'(count_q - 1'b1);
          done_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Report the count left after the operation
    if (done_d) begin
      count_ext         = {5'b0, count_d};
      rsp_d.entry_count = count_ext[4:0];
      rsp_d.is_empty    = (count_d == '0);
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      newest_q <= '0;
      count_q  <= '0;
      slot_q   <= '0;
      lidx_q   <= '0;
      moves_q  <= '0;
      req_q    <= '0;
      rsp_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      newest_q <= newest_d;
      count_q  <= count_d;
      slot_q   <= slot_d;
      lidx_q   <= lidx_d;
      moves_q  <= moves_d;
      req_q    <= req_d;
      rsp_q    <= rsp_d;
      done_q   <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  // Occupancy never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("entry count above capacity");

  // A result only follows a transfer or an operation in progress
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i || busy_o))
    else $error("result without an operation");

  // Reported emptiness matches the held count
  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.is_empty == (count_q == '0)))
    else $error("empty flag disagrees with count");

  // Compaction never reads the slot it writes while more moves remain
  a_shift_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && moves_q > CW'(1)) |-> (ram_waddr != ram_raddr))
    else $error("compaction read and write collide");

  // A scan never runs past the oldest entry
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (lidx_q < count_q))
    else $error("scan beyond held entries");
`endif

endmodule

[rtl/kmb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// A read of the address written in the same cycle returns the old contents.
// Defaults come from kmb_pkg.
module kmb_ram #(
  parameter int unsigned WIDTH = kmb_pkg::ENTRY_W,
  parameter int unsigned DEPTH = kmb_pkg::DEFAULT_CAPACITY,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[dv/tb.sv]
// Testbench for keyed_message_buffer_core: directed and random insert, peek, remove and clear
// operations, checked against an age-ordered entry model kept in a scoreboard class.
// Depends on kmb_pkg and the keyed_message_buffer_core RTL.
`timescale 1ns / 100ps

module tb;
  import kmb_pkg::*;

  localparam int DEPTH        = kmb_pkg::DEFAULT_CAPACITY;
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 2 * DEPTH + 8;
  localparam int RANDOM_ITEMS = 650;
  localparam int CALM_FROM    = 560;

  typedef enum int {KEY_POOL, KEY_LIVE, KEY_NEAR, KEY_RANDOM} key_src_e;

  // Age-ordered copy of the buffer and the queue of results still to come
  class kmb_scoreboard;
    entry_t held[DEPTH];
    int     held_count;
    rsp_t   expected_q[$];
    int     mismatch_count;

    function new();
      held_count     = 0;
      mismatch_count = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      $display("[%0t] MISMATCH %s: got %0h want %0h", $time, what, got, want);
    endtask

    // Apply one accepted transfer to the entry copy and queue its result
    function void note_request(req_t r);
      rsp_t e;
      int   hit;
      int   i;
      e = '0;
      case (r.func)
        FUNC_INSERT: begin
          if (held_count >= DEPTH) begin
            e.evicted  = 1'b1;
            held_count = DEPTH - 1;
          end
          for (i = held_count; i > 0; i--) held[i] = held[i-1];
          held[0].seq_num   = r.seq_num;
          held[0].peer_addr = r.peer_addr;
          held[0].peer_port = r.peer_port;
          held[0].payload   = r.payload;
          held_count++;
        end
        FUNC_PEEK, FUNC_REMOVE: begin
          hit = -1;
          for (i = 0; i < held_count; i++) begin
            if (hit < 0 && held[i].seq_num == r.seq_num && held[i].peer_addr == r.peer_addr &&
                held[i].peer_port == r.peer_port)
              hit = i;
          end
          if (hit >= 0) begin
            e.found       = 1'b1;
            e.payload_out = held[hit].payload;
            if (r.func == FUNC_REMOVE) begin
              for (i = hit; i + 1 < held_count; i++) held[i] = held[i+1];
              held_count--;
            end
          end
        end
        default: held_count = 0;
      endcase
      e.entry_count = held_count[4:0];
      e.is_empty    = (held_count == 0);
      expected_q.push_back(e);
    endfunction

    // Compare one result with the oldest outstanding expectation
    task check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no operation outstanding", got.entry_count, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found) report_mismatch("found", got.found, want.found);
      if (got.payload_out !== want.payload_out)
        report_mismatch("payload_out", got.payload_out, want.payload_out);
      if (got.evicted !== want.evicted) report_mismatch("evicted", got.evicted, want.evicted);
      if (got.entry_count !== want.entry_count)
        report_mismatch("entry_count", got.entry_count, want.entry_count);
      if (got.is_empty !== want.is_empty)
        report_mismatch("is_empty", got.is_empty, want.is_empty);
    endtask

    task check_leftover();
      while (expected_q.size() > 0) begin
        report_mismatch("result never arrived, entry_count", 0, expected_q[0].entry_count);
        void'(expected_q.pop_front());
      end
    endtask
  endclass

  logic  clk_i   = 1'b0;
  logic  rst_ni  = 1'b0;
  logic  start_i = 1'b0;
  req_t  req_i   = '0;
  logic  busy_o;
  logic  done_o;
  rsp_t  rsp_o;

  kmb_scoreboard sb;
  int            stall_cycles;
  logic [31:0]   seq_pool[4];
  logic [31:0]   addr_pool[3];
  logic [15:0]   port_pool[3];

  keyed_message_buffer_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Check results, record accepted transfers and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_response(rsp_o);
      if (start_i && !busy_o) sb.note_request(req_i);
      if (done_o || (start_i && !busy_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("keyed_message_buffer_core verification failed");
          $finish;
        end
      end
    end
  end

  function automatic req_t mk(func_e f, logic [31:0] s, logic [31:0] a, logic [15:0] p,
                              logic [63:0] d);
    req_t r;
    r.func      = f;
    r.seq_num   = s;
    r.peer_addr = a;
    r.peer_port = p;
    r.payload   = d;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Build a request whose key comes from the chosen source
  function automatic req_t build_request(func_e f, key_src_e src);
    req_t r;
    int   idx;
    r = mk(f, seq_pool[$urandom_range(0, 3)], addr_pool[$urandom_range(0, 2)],
           port_pool[$urandom_range(0, 2)], rand64());
    if ((src == KEY_LIVE || src == KEY_NEAR) && sb.held_count > 0) begin
      idx         = $urandom_range(0, sb.held_count - 1);
      r.seq_num   = sb.held[idx].seq_num;
      r.peer_addr = sb.held[idx].peer_addr;
      r.peer_port = sb.held[idx].peer_port;
      // Near miss: one key bit off so only part of the key matches
      if (src == KEY_NEAR) begin
        case ($urandom_range(0, 2))
          0:       r.seq_num[$urandom_range(0, 31)]   = ~r.seq_num[0 +: 1];
          1:       r.peer_addr = r.peer_addr ^ (32'd1 << $urandom_range(0, 31));
          default: r.peer_port = r.peer_port ^ (16'd1 << $urandom_range(0, 15));
        endcase
        if (r.seq_num == sb.held[idx].seq_num && r.peer_addr == sb.held[idx].peer_addr &&
            r.peer_port == sb.held[idx].peer_port)
          r.seq_num = r.seq_num ^ (32'd1 << $urandom_range(0, 31));
      end
    end else if (src == KEY_RANDOM) begin
      r.seq_num   = $urandom;
      r.peer_addr = $urandom;
      r.peer_port = 16'($urandom_range(0, 65535));
    end
    return r;
  endfunction

  // Drive one transfer from a falling edge and hold it until taken; ends on a falling edge
  task automatic send(req_t r);
    start_i = 1'b1;
    req_i   = r;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic idle(int cycles);
    start_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain();
    start_i = 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
  endtask

  task automatic run_directed();
    int i;
    send(mk(FUNC_CLEAR, 32'd0, 32'd0, 16'd0, 64'd0));
    send(mk(FUNC_PEEK, 32'd0, 32'd0, 16'd0, 64'd0));
    send(mk(FUNC_REMOVE, '1, '1, '1, '1));
    send(mk(FUNC_INSERT, 32'd0, 32'd0, 16'd0, 64'd0));
    send(mk(FUNC_INSERT, '1, '1, '1, '1));
    send(mk(FUNC_PEEK, '1, '1, '1, 64'd0));
    send(mk(FUNC_PEEK, 32'd0, 32'd0, 16'd0, '1));
    send(mk(FUNC_PEEK, '1, '1, 16'd0, 64'd0));
    // Fill to capacity, with a duplicate of the all-zero key among the entries
    send(mk(FUNC_INSERT, 32'd0, 32'd0, 16'd0, 64'h0123_4567_89ab_cdef));
    for (i = 0; i < DEPTH - 3; i++) send(build_request(FUNC_INSERT, KEY_POOL));
    // Insert when full drops the oldest entry
    send(build_request(FUNC_INSERT, KEY_RANDOM));
    send(build_request(FUNC_INSERT, KEY_POOL));
    send(mk(FUNC_PEEK, 32'd0, 32'd0, 16'd0, 64'd0));
    send(mk(FUNC_REMOVE, sb.held[sb.held_count-1].seq_num, sb.held[sb.held_count-1].peer_addr,
            sb.held[sb.held_count-1].peer_port, rand64()));
    send(mk(FUNC_REMOVE, sb.held[7].seq_num, sb.held[7].peer_addr, sb.held[7].peer_port,
            rand64()));
    send(mk(FUNC_REMOVE, sb.held[0].seq_num, sb.held[0].peer_addr, sb.held[0].peer_port,
            rand64()));
    send(build_request(FUNC_PEEK, KEY_NEAR));
    send(mk(FUNC_CLEAR, '1, '1, '1, '1));
    send(build_request(FUNC_REMOVE, KEY_POOL));
  endtask

  task automatic run_random();
    int       n;
    int       roll;
    int       insert_pct;
    bit       gaps_on;
    func_e    f;
    key_src_e src;
    gaps_on = 1'b1;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (n == 200 || n == 420) drain();
      if (n < CALM_FROM && gaps_on && $urandom_range(0, 3) == 0) idle($urandom_range(1, 8));
      // Alternate filling and emptying phases so both ends of occupancy get exercised
      insert_pct = ((n / 80) % 2 == 0) ? 52 : 28;
      roll       = $urandom_range(0, 99);
      if (roll < insert_pct)          f = FUNC_INSERT;
      else if (roll < insert_pct + 30) f = FUNC_PEEK;
      else if (roll < 98)             f = FUNC_REMOVE;
      else                            f = FUNC_CLEAR;
      roll = $urandom_range(0, 99);
      if (f == FUNC_INSERT) src = (roll < 75) ? KEY_POOL : (roll < 85) ? KEY_LIVE : KEY_RANDOM;
      else src = (roll < 55) ? KEY_LIVE : (roll < 70) ? KEY_NEAR :
                 (roll < 90) ? KEY_POOL : KEY_RANDOM;
      send(build_request(f, src));
    end
  endtask

  initial begin
    sb           = new();
    stall_cycles = 0;
    seq_pool     = '{32'd0, '1, $urandom, $urandom};
    addr_pool    = '{32'd0, '1, $urandom};
    port_pool    = '{16'd0, '1, 16'($urandom)};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();
    drain();
    run_random();

    // Let the last results arrive, then watch for stray strobes
    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    sb.check_leftover();
    if (sb.mismatch_count == 0) begin
      $display("keyed_message_buffer_core verification clean");
    end else begin
      $display("keyed_message_buffer_core verification failed");
    end
    $finish;
  end

endmodule

[keyed_message_buffer_core.f]
rtl/kmb_pkg.sv
rtl/kmb_ram.sv
rtl/keyed_message_buffer_core.sv
dv/tb.sv
